// ===== design/idd_pkg.sv =====
// idd_pkg: shared constants for the index deduplicator.
// Used by the channel interfaces and the top level.
`default_nettype none

package idd_pkg;

    // Bitmap span and derived address width
    localparam int SPAN_ENTRIES = 4096;
    localparam int ADDR_W       = $clog2(SPAN_ENTRIES);

    // Index and count widths
    localparam int INDEX_W   = 32;
    localparam int COUNT_W   = 13;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Epoch tags stored per bitmap entry; zero marks a cleared entry
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_INDEX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_INDEX  = 1'b1;

    // Register reset values
    localparam logic signed [INDEX_W-1:0] BASE_RESET = 32'sd0;
    localparam logic signed [INDEX_W-1:0] TOP_RESET  = 32'sd4095;

endpackage

`default_nettype wire

// ===== design/idd_in_if.sv =====
// idd_in_if: input channel of the index deduplicator (valid/ready plus one index).
// Depends on idd_pkg for field widths.
`default_nettype none

interface idd_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [idd_pkg::INDEX_W-1:0]    index_value;
    logic                                  set_last;

    modport source (output valid, output index_value, output set_last, input ready);
    modport sink   (input valid, input index_value, input set_last, output ready);
endinterface

`default_nettype wire

// ===== design/idd_out_if.sv =====
// idd_out_if: result channel of the index deduplicator (valid/ready plus one result).
// Depends on idd_pkg for field widths.
`default_nettype none

interface idd_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [idd_pkg::INDEX_W-1:0]    kept_value;
    logic                                  is_new;
    logic                                  out_of_range;
    logic        [idd_pkg::COUNT_W-1:0]    unique_count;
    logic                                  set_end;

    modport source (output valid, output kept_value, output is_new, output out_of_range,
                    output unique_count, output set_end, input ready);
    modport sink   (input valid, input kept_value, input is_new, input out_of_range,
                    input unique_count, input set_end, output ready);
endinterface

`default_nettype wire

// ===== design/idd_ram.sv =====
// idd_ram: generic single-write, single-read synchronous RAM with registered read.
// Read during a write to the same address returns the old contents. No dependencies.
`default_nettype none

module idd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/index_deduplicator.sv =====
// index_deduplicator: bitmap deduplication of an index stream, one result per index.
// Depends on idd_pkg, idd_in_if, idd_out_if and idd_ram.
//
//   Channel   Dir   Handshake      Payload
//   i_in      in    valid/ready    index_value, set_last
//   o_out     out   valid/ready    kept_value, is_new, out_of_range, unique_count, set_end
//   i_cfg_*   in    write enable   register index, 32-bit data
//
// One item per cycle unless the output stalls or a sweep runs; an item passes the lookup
// stage, then the output register. The bitmap RAM does one read and one write per cycle,
// and a repeat of the item just ahead is forwarded. Each bitmap entry holds an epoch tag;
// the end of a vector advances the epoch instead of clearing the RAM. After reset and
// after every 255th vector the RAM is swept to zero over all SPAN_ENTRIES entries, during
// which no item is accepted. A stalled result holds in the output register; a new item is
// still taken if the stage ahead of it is free.
`default_nettype none

module index_deduplicator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    idd_in_if.sink                                 i_in,
    idd_out_if.source                              o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [idd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [idd_pkg::INDEX_W-1:0]       i_cfg_data
);

    localparam int AW = idd_pkg::ADDR_W;
    localparam int IW = idd_pkg::INDEX_W;
    localparam int CW = idd_pkg::COUNT_W;
    localparam int EW = idd_pkg::EPOCH_W;

    // Configuration registers
    logic signed [IW-1:0] r_base;
    logic signed [IW-1:0] r_top;

    // Lookup stage
    logic                 r_s1_v;
    logic signed [IW-1:0] r_s1_value;
    logic                 r_s1_last;
    logic                 r_s1_inr;
    logic [AW-1:0]        r_s1_pos;

    // Forwarding of the most recent bitmap write
    logic                 r_fwd_v;
    logic [AW-1:0]        r_fwd_pos;

    // Vector state and clearing sweep
    logic [EW-1:0]        r_epoch;
    logic [CW-1:0]        r_count;
    logic                 r_clearing;
    logic [AW-1:0]        r_clr_addr;

    // Output register
    logic                 r_out_v;
    logic signed [IW-1:0] r_out_value;
    logic                 r_out_new;
    logic                 r_out_oor;
    logic [CW-1:0]        r_out_count;
    logic                 r_out_end;

    // Combinational signals
    logic signed [IW:0]   off;
    logic                 in_range;
    logic                 in_acc;
    logic                 s1_go;
    logic                 wrap_pending;
    logic [EW-1:0]        rd_data;
    logic                 seen;
    logic                 s1_new;
    logic [CW-1:0]        n_count;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [EW-1:0]        ram_wdata;

    // Offset from base and span check
    assign off      = {i_in.index_value[IW-1], i_in.index_value} - {r_base[IW-1], r_base};
    assign in_range = !off[IW] && (off < (IW+1)'(idd_pkg::SPAN_ENTRIES))
                      && (i_in.index_value <= r_top);

    // Handshakes: stop taking items when a sweep is running or about to start
    assign s1_go        = r_s1_v && (!r_out_v || o_out.ready);
    assign wrap_pending = r_s1_v && r_s1_last && (r_epoch == idd_pkg::EPOCH_MAX);
    assign i_in.ready   = !r_clearing && !wrap_pending && (!r_s1_v || s1_go);
    assign in_acc       = i_in.valid && i_in.ready;

    // Decide new or repeat from RAM data or the forwarded write
    assign seen    = (r_fwd_v && (r_fwd_pos == r_s1_pos)) || (rd_data == r_epoch);
    assign s1_new  = r_s1_inr && !seen;
    assign n_count = (s1_new && (r_count != idd_pkg::COUNT_MAX)) ? r_count + CW'(1) : r_count;

    // RAM write port: sweep or bitmap update
    always_comb begin
        if (r_clearing) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = idd_pkg::EPOCH_NONE;
        end else begin
            ram_we    = s1_go && s1_new;
            ram_waddr = r_s1_pos;
            ram_wdata = r_epoch;
        end
    end

    idd_ram #(
        .WIDTH (EW),
        .DEPTH (idd_pkg::SPAN_ENTRIES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (off[AW-1:0]),
        .o_rdata (rd_data)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= idd_pkg::BASE_RESET;
            r_top  <= idd_pkg::TOP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                idd_pkg::CFG_BASE_INDEX: r_base <= i_cfg_data;
                idd_pkg::CFG_TOP_INDEX:  r_top  <= i_cfg_data;
            endcase
        end
    end

    // Lookup stage: load on accept, drop when passed on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (in_acc) begin
            r_s1_v <= 1'b1;
        end else if (s1_go) begin
            r_s1_v <= 1'b0;
        end
        if (in_acc) begin
            r_s1_value <= i_in.index_value;
            r_s1_last  <= i_in.set_last;
            r_s1_inr   <= in_range;
            r_s1_pos   <= off[AW-1:0];
        end
    end

    // Vector state: count, epoch, forwarding and clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_epoch    <= idd_pkg::EPOCH_FIRST;
            r_fwd_v    <= 1'b0;
            r_fwd_pos  <= '0;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(idd_pkg::SPAN_ENTRIES - 1)) begin
                r_clearing <= 1'b0;
                r_clr_addr <= '0;
                r_epoch    <= idd_pkg::EPOCH_FIRST;
            end
        end else if (s1_go) begin
            r_fwd_v   <= s1_new && !r_s1_last;
            r_fwd_pos <= r_s1_pos;
            if (r_s1_last) begin
                r_count <= '0;
                if (r_epoch == idd_pkg::EPOCH_MAX) begin
                    r_clearing <= 1'b1;
                end else begin
                    r_epoch <= r_epoch + EW'(1);
                end
            end else begin
                r_count <= n_count;
            end
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_go) begin
            r_out_v <= 1'b1;
        end else if (o_out.ready) begin
            r_out_v <= 1'b0;
        end
        if (s1_go) begin
            r_out_value <= r_s1_value;
            r_out_new   <= s1_new;
            r_out_oor   <= !r_s1_inr;
            r_out_count <= n_count;
            r_out_end   <= r_s1_last;
        end
    end

    assign o_out.valid        = r_out_v;
    assign o_out.kept_value   = r_out_value;
    assign o_out.is_new       = r_out_new;
    assign o_out.out_of_range = r_out_oor;
    assign o_out.unique_count = r_out_count;
    assign o_out.set_end      = r_out_end;

    // No item enters while the sweep runs
    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !i_in.ready)
        else $error("item accepted during bitmap sweep");

    // A stalled lookup keeps its RAM data
    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !s1_go) |=> $stable(rd_data))
        else $error("lookup data changed while stalled");

    // A kept index is always in range
    a_new_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_new) |-> !r_out_oor)
        else $error("kept index flagged out of range");

    // The live epoch never equals the cleared tag
    a_epoch_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clearing |-> (r_epoch != idd_pkg::EPOCH_NONE))
        else $error("epoch collides with cleared tag");

    // The lookup stage is empty when a sweep starts
    a_sweep_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_clearing) |-> !r_s1_v)
        else $error("item in flight at sweep start");

endmodule

`default_nettype wire
